// ===== rtl/line_command_keyword_matcher_unit_macros.svh =====
// Assertion helpers used by the matcher top module.
`ifndef LINE_COMMAND_KEYWORD_MATCHER_UNIT_MACROS_SVH
`define LINE_COMMAND_KEYWORD_MATCHER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LCKM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LCKM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lckm_pkg.sv =====
package lckm_pkg;

  localparam int NUM_KEYWORDS_DEF    = 8;
  localparam int MAX_KEYWORD_LEN_DEF = 16;

  // Keyword table: rows beyond the last keyword are empty strings.
  localparam int KW_ROWS = 16;
  localparam int KW_COLS = 40;
  localparam int KW_BITS = 8 * KW_COLS;

  localparam int IDX_W = 4;
  localparam int CMD_W = 4;

  localparam logic [7:0]       NEWLINE_BYTE  = 8'd10;
  localparam logic [CMD_W-1:0] CMD_NONE      = 4'd8;

  // String literals are right-aligned, first character in the highest used byte.
  localparam logic [KW_BITS-1:0] KW_RAW [KW_ROWS] = '{
    KW_BITS'({"led_all", "_on"}),
    KW_BITS'({"led_all", "_off"}),
    KW_BITS'({"led_left", "_on"}),
    KW_BITS'({"led_right", "_on"}),
    KW_BITS'({"led_flower", "_on"}),
    KW_BITS'({"led_flower", "_off"}),
    KW_BITS'({"led_left", "_keepon"}),
    KW_BITS'({"led_right", "_keepon"}),
    '0, '0, '0, '0, '0, '0, '0, '0
  };

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] index;
  } match_t;

  typedef struct packed {
    logic             found;
    logic [2:0]       index;
    logic [CMD_W-1:0] command;
  } result_t;

  function automatic int kw_raw_len(input int k);
    int n;
    n = 0;
    for (int i = 0; i < KW_COLS; i++) begin
      if (KW_RAW[k][8*i +: 8] != 8'd0) n++;
    end
    return n;
  endfunction

  // Keyword length as seen by a matcher that looks at max_len bytes at most.
  function automatic int kw_len(input int k, input int max_len);
    int n;
    n = kw_raw_len(k);
    return (n < max_len) ? n : max_len;
  endfunction

  // Character p of keyword k, counted from the start of the keyword.
  function automatic logic [7:0] kw_char(input int k, input int p);
    int         l;
    logic [7:0] c;
    l = kw_raw_len(k);
    c = 8'd0;
    if (p < l) c = KW_RAW[k][8*(l-1-p) +: 8];
    return c;
  endfunction

endpackage

// ===== rtl/line_command_keyword_matcher_unit.sv =====
// An accepted newline's result leaves from out_reg, via skid_reg while out_reg is held.
// Throughput: one byte item per cycle; bytes other than newline give no result item.
// The input stalls only while the skid register holds a second unsent result.
// Reset: position 0, every keyword flag set, current command 8 (none), no result pending.
module line_command_keyword_matcher_unit #(
  parameter int NUM_KEYWORDS    = lckm_pkg::NUM_KEYWORDS_DEF,
  parameter int MAX_KEYWORD_LEN = lckm_pkg::MAX_KEYWORD_LEN_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                rx_byte,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      keyword_found,
  output logic [2:0]                keyword_index,
  output logic [lckm_pkg::CMD_W-1:0] current_command
);
  import lckm_pkg::*;
  `include "line_command_keyword_matcher_unit_macros.svh"

  localparam int PosW = $clog2(MAX_KEYWORD_LEN + 1);

  logic            accept;
  logic            is_newline;
  logic            step;
  logic            line_end;
  logic [PosW-1:0] line_pos;
  logic [CMD_W-1:0] selected_cmd;
  logic [CMD_W-1:0] selected_cmd_next;
  match_t          chain [NUM_KEYWORDS+1];
  result_t         result_next;
  result_t         out_reg;
  result_t         skid_reg;
  logic            skid_valid;
  logic            out_take;

  // Hold the input whenever a second result is parked in the skid stage.
  assign in_stall   = skid_valid;
  assign accept     = in_valid && !in_stall;
  assign is_newline = (rx_byte == NEWLINE_BYTE);
  // Bytes past the compare window are dropped; the position saturates.
  assign step       = accept && !is_newline && (line_pos < PosW'(MAX_KEYWORD_LEN));
  assign line_end   = accept && is_newline;

  always_ff @(posedge clk) begin
    if (rst || line_end) begin
      line_pos <= '0;
    end else if (step) begin
      line_pos <= line_pos + PosW'(1);
    end
  end

  // Row of keyword cells; the priority chain runs from keyword 0 upwards.
  assign chain[0] = '0;
  for (genvar k = 0; k < NUM_KEYWORDS; k++) begin : g_cell
    lckm_cell #(
      .K               (k),
      .MAX_KEYWORD_LEN (MAX_KEYWORD_LEN)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .rx_byte   (rx_byte),
      .line_pos  (line_pos),
      .step      (step),
      .line_end  (line_end),
      .chain_in  (chain[k]),
      .chain_out (chain[k+1])
    );
  end

  // A match replaces the sticky command; otherwise keep it.
  always_comb begin
    selected_cmd_next = chain[NUM_KEYWORDS].found ?
                        CMD_W'(chain[NUM_KEYWORDS].index) : selected_cmd;
    result_next.found   = chain[NUM_KEYWORDS].found;
    result_next.index   = chain[NUM_KEYWORDS].found ?
                          chain[NUM_KEYWORDS].index[2:0] : 3'd0;
    result_next.command = selected_cmd_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      selected_cmd <= CMD_NONE;
    end else if (line_end) begin
      selected_cmd <= selected_cmd_next;
    end
  end

  // Output register with a skid stage behind it.
  assign out_take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= line_end;
      end
    end else if (line_end) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_take) begin
      if (skid_valid) begin
        out_reg <= skid_reg;
      end else if (line_end) begin
        out_reg <= result_next;
      end
    end else if (line_end) begin
      skid_reg <= result_next;
    end
  end

  assign keyword_found   = out_reg.found;
  assign keyword_index   = out_reg.index;
  assign current_command = out_reg.command;

  `LCKM_ASSERT_IMP(a_skid_behind_out, skid_valid, out_valid,
    "skid stage holds an item while the output register is empty")
  `LCKM_ASSERT_NXT(a_line_restart, line_end, line_pos == '0,
    "line position not cleared after a newline")
  `LCKM_ASSERT_NXT(a_cmd_sticky, !line_end, $stable(selected_cmd),
    "current command changed without a newline")
  `LCKM_ASSERT_IMP(a_found_cmd, out_valid && keyword_found,
    current_command[2:0] == keyword_index,
    "reported command disagrees with the matched keyword")

endmodule

// ===== rtl/lckm_cell.sv =====
module lckm_cell #(
  parameter int K               = 0,
  parameter int MAX_KEYWORD_LEN = lckm_pkg::MAX_KEYWORD_LEN_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic [7:0]                                 rx_byte,
  input  logic [$clog2(MAX_KEYWORD_LEN+1)-1:0]      line_pos,
  input  logic                                       step,
  input  logic                                       line_end,
  input  lckm_pkg::match_t                           chain_in,
  output lckm_pkg::match_t                           chain_out
);
  import lckm_pkg::*;

  localparam int PosW = $clog2(MAX_KEYWORD_LEN + 1);
  localparam int Len  = kw_len(K, MAX_KEYWORD_LEN);

  logic                       alive;
  logic [MAX_KEYWORD_LEN-1:0] miss;
  logic                       mismatch;
  logic                       hit;

  // One comparator per keyword character position; only the one at the current position can fire.
  for (genvar p = 0; p < MAX_KEYWORD_LEN; p++) begin : g_pos
    if (p < Len) begin : g_cmp
      localparam logic [7:0] Ch = kw_char(K, p);
      assign miss[p] = (line_pos == PosW'(p)) && (rx_byte != Ch);
    end else begin : g_none
      assign miss[p] = 1'b0;
    end
  end

  assign mismatch = |miss;
  assign hit      = alive && (line_pos >= PosW'(Len));

  always_ff @(posedge clk) begin
    if (rst || line_end) begin
      alive <= 1'b1;
    end else if (step && mismatch) begin
      alive <= 1'b0;
    end
  end

  // Lower index wins: pass an earlier hit through untouched.
  always_comb begin
    chain_out.found = chain_in.found || hit;
    chain_out.index = chain_in.found ? chain_in.index : IDX_W'(K);
  end

endmodule

// ===== sim/line_command_keyword_matcher_unit_test.sv =====
class lckm_scoreboard;
  string                                  words[lckm_pkg::NUM_KEYWORDS_DEF];
  logic [4:0]                             line_pos;
  logic [lckm_pkg::NUM_KEYWORDS_DEF-1:0]  alive;
  logic [lckm_pkg::CMD_W-1:0]             sel_cmd;
  lckm_pkg::result_t                      awaited_q[$];
  int                                     errors;
  int                                     checked;
  int                                     matched;
  int                                     lines;

  function new();
    string pre;
    pre      = "led_";
    words[0] = {pre, "all_on"};
    words[1] = {pre, "all_off"};
    words[2] = {pre, "left_on"};
    words[3] = {pre, "right_on"};
    words[4] = {pre, "flower_on"};
    words[5] = {pre, "flower_off"};
    words[6] = {pre, "left_keepon"};
    words[7] = {pre, "right_keepon"};
    line_pos = '0;
    alive    = '1;
    sel_cmd  = lckm_pkg::CMD_NONE;
    errors   = 0;
    checked  = 0;
    matched  = 0;
    lines    = 0;
  endfunction

  // Track the line so far; a newline closes it and queues the awaited result.
  function void note_byte(logic [7:0] b);
    lckm_pkg::result_t r;
    if (b != lckm_pkg::NEWLINE_BYTE) begin
      if (line_pos < lckm_pkg::MAX_KEYWORD_LEN_DEF) begin
        for (int k = 0; k < lckm_pkg::NUM_KEYWORDS_DEF; k++) begin
          if (line_pos < words[k].len() && 8'(words[k][line_pos]) != b) alive[k] = 1'b0;
        end
        line_pos++;
      end
      return;
    end
    r = '0;
    // walk downwards so that the lowest matching keyword is the one kept
    for (int k = lckm_pkg::NUM_KEYWORDS_DEF - 1; k >= 0; k--) begin
      if (alive[k] && words[k].len() <= line_pos) begin
        r.found = 1'b1;
        r.index = 3'(k);
      end
    end
    if (r.found) begin
      sel_cmd = lckm_pkg::CMD_W'(r.index);
      matched++;
    end
    r.command = sel_cmd;
    awaited_q.push_back(r);
    lines++;
    line_pos = '0;
    alive    = '1;
  endfunction

  task report(string what, logic [7:0] got, logic [7:0] want);
    $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  task check_result(logic found, logic [2:0] index, logic [lckm_pkg::CMD_W-1:0] command);
    lckm_pkg::result_t w;
    if (awaited_q.size() == 0) begin
      report("result with none awaited, keyword_index", 8'(index), 8'd0);
      return;
    end
    w = awaited_q.pop_front();
    checked++;
    if (found !== w.found) report("keyword_found", 8'(found), 8'(w.found));
    if (index !== w.index) report("keyword_index", 8'(index), 8'(w.index));
    if (command !== w.command) report("current_command", 8'(command), 8'(w.command));
  endtask
endclass

module line_command_keyword_matcher_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lckm_pkg::*;

  localparam int RANDOM_BYTES = 900;
  localparam int HOLD_CYCLES  = 150;
  localparam int QUIET_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 4;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       rx_byte = 8'd0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             keyword_found;
  logic [2:0]       keyword_index;
  logic [CMD_W-1:0] current_command;

  lckm_scoreboard sb;

  int         send_idle_pct  = 0;
  int         recv_stall_pct = 0;
  int         hold_asked     = 0;
  int         hold_given     = 0;
  int         hold_left      = 0;
  int         quiet_cycles   = 0;
  int         sent_bytes     = 0;
  logic [7:0] line_buf[$];

  line_command_keyword_matcher_unit i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .keyword_found  (keyword_found),
    .keyword_index  (keyword_index),
    .current_command(current_command)
  );

  always #10 clk = ~clk;

  // Receiver: stall at random at the rate of the current phase, or hold off
  // for a long run of cycles when the stimulus asks for it. The long hold is
  // counted here so that the sender keeps offering bytes meanwhile.
  always @(posedge clk) begin
    if (hold_asked != hold_given) begin
      hold_given = hold_asked;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Check every result item taken at this edge; values sampled here are the
  // ones that stood before the edge.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_result(keyword_found, keyword_index, current_command);
    end
  end

  // Count cycles in which neither side moves an item.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("timed out after %0d cycles without progress, %0d results outstanding",
             quiet_cycles, sb.awaited_q.size());
    $display("line_command_keyword_matcher_unit_test NOT OK");
    $finish;
  end

  function automatic logic [7:0] rand_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(255));
    end while (b == NEWLINE_BYTE);
    return b;
  endfunction

  // Offer one byte, idling first at the sender's rate; return once it is taken.
  // Valid is left high afterwards so that back-to-back bytes never drop it.
  task automatic send_byte(logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_byte(b);
    sent_bytes++;
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(8'(s[i]));
  endtask

  // Send the buffered line followed by its newline, then empty the buffer.
  task automatic send_line();
    foreach (line_buf[i]) send_byte(line_buf[i]);
    send_byte(NEWLINE_BYTE);
    line_buf.delete();
  endtask

  // Drop valid so the last byte is not taken twice, then wait for every result.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.awaited_q.size() != 0) @(posedge clk);
  endtask

  // Well-formed commands with random tails, damaged commands
  // (a byte swapped, cut short, a NUL dropped in) and some plain noise.
  task automatic add_random_line();
    int    kind;
    int    k;
    int    n;
    string w;
    kind = $urandom_range(99);
    k    = $urandom_range(NUM_KEYWORDS_DEF - 1);
    w    = sb.words[k];
    if (kind < 45) begin
      put_text(w);
      n = $urandom_range(6);
      repeat (n) line_buf.push_back(rand_byte());
    end else if (kind < 62) begin
      put_text(w);
      line_buf[$urandom_range(w.len() - 1)] = rand_byte();
    end else if (kind < 77) begin
      n = $urandom_range(w.len() - 1);
      for (int i = 0; i < n; i++) line_buf.push_back(8'(w[i]));
    end else if (kind < 88) begin
      n = $urandom_range(20);
      repeat (n) line_buf.push_back(rand_byte());
    end else begin
      put_text(w);
      line_buf[$urandom_range(w.len() - 1)] = 8'h00;
    end
    send_line();
  endtask

  initial begin
    int target;
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed lines, run with sender gaps and a busy receiver.
    send_idle_pct = 18;
    recv_stall_pct <= 87;
    // empty line before any match: current command still reads none
    send_line();
    put_text("hello");
    send_line();
    foreach (sb.words[k]) begin
      put_text(sb.words[k]);
      send_line();
    end
    // cut short by one character
    put_text("led_all_o");
    send_line();
    // keyword followed by a tail that runs past the saturating position
    put_text(sb.words[7]);
    put_text("_and_then_some");
    send_line();
    put_text(sb.words[0]);
    put_text("XYZ");
    send_line();
    // NUL in the middle ends every compare
    put_text("led_");
    line_buf.push_back(8'h00);
    put_text("all_on");
    send_line();
    // extreme byte values
    line_buf.push_back(8'hff);
    line_buf.push_back(8'h00);
    send_line();
    put_text("led_flower_of");
    send_line();

    // Random lines in three phases: slow receiver, slow sender, then full rate.
    for (int ph = 0; ph < 3; ph++) begin
      // hold the sender until every awaited result has come out
      wait_drained();
      case (ph)
        0: begin
          send_idle_pct = 18;
          recv_stall_pct <= 87;
        end
        1: begin
          send_idle_pct = 87;
          recv_stall_pct <= 18;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct <= 0;
          // long receiver hold-off while bytes keep coming, to fill the block
          hold_asked <= hold_asked + 1;
        end
      endcase
      target = sent_bytes + RANDOM_BYTES / 3;
      while (sent_bytes < target) add_random_line();
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d bytes in %0d lines: %0d results checked, %0d keyword matches",
             sent_bytes, sb.lines, sb.checked, sb.matched);
    $display("phases: slow receiver, slow sender, full rate with a %0d-cycle hold-off",
             HOLD_CYCLES);
    if (sb.errors == 0 && sb.awaited_q.size() == 0) begin
      $display("line_command_keyword_matcher_unit_test OK");
    end else begin
      $display("line_command_keyword_matcher_unit_test NOT OK");
    end
    $finish;
  end
endmodule
